// ===== hw/rtl/pbms_pkg.sv =====
`default_nettype none
package pbms_pkg;

    // table geometry
    localparam int NUM_BINS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int BIN_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    // field and state widths
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 8;
    localparam int SMP_IN_W = 16;
    localparam int SMP_W    = SMP_IN_W + 1;
    localparam int STAT_W   = 2;
    localparam int SUM_W    = 40;
    localparam int SQ_W     = 56;
    localparam int CNT_W    = 24;
    localparam int ENT_W    = SUM_W + SQ_W + CNT_W;
    localparam int MEAN_W   = 17;
    localparam int MOUT_W   = 16;
    localparam int VAR_W    = 31;
    localparam int SD_W     = 16;
    localparam int TSUM_W   = SUM_W + BIN_W + 1;
    localparam int TCNT_W   = CNT_W + BIN_W + 1;
    localparam int VSUM_W   = VAR_W + BIN_W + 1;

    // shared divider and square root unit
    localparam int DIV_N_W    = SQ_W;
    localparam int DIV_D_W    = TCNT_W;
    localparam int DIV_STEP_W = $clog2(DIV_N_W + 1);
    localparam int SQRT_STEPS = (VAR_W + 1) / 2;
    localparam int SQRT_W     = 2 * SQRT_STEPS;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // request function codes
    localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_GLOBAL = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_BIN = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_DIVM,
        S_DIVQ,
        S_MUL,
        S_VAR,
        S_GEND,
        S_GDIVM,
        S_SQRT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic ram_we;
        logic div_start;
        logic sqrt_start;
    } t_ctrl;

endpackage
`default_nettype wire

// ===== hw/rtl/pbms_ram.sv =====
`default_nettype none
module pbms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/pbms_div.sv =====
`default_nettype none
module pbms_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pbms_pkg::DIV_N_W-1:0]   i_dividend,
    input  wire logic [pbms_pkg::DIV_D_W-1:0]   i_divisor,
    output logic                                o_busy,
    output logic                                o_done,
    output logic      [pbms_pkg::DIV_N_W-1:0]   o_quotient
);
    localparam int N = pbms_pkg::DIV_N_W;
    localparam int D = pbms_pkg::DIV_D_W;

    logic                             r_busy;
    logic                             r_done;
    logic [pbms_pkg::DIV_STEP_W-1:0]  r_step;
    logic [D-1:0]                     r_rem;
    logic [N-1:0]                     r_quo;
    logic [D-1:0]                     r_div;
    logic [D:0]                       w_try;
    logic [D:0]                       w_diff;
    logic                             w_ge;

    // one restoring step per cycle
    always_comb begin
        w_try  = {r_rem, r_quo[N-1]};
        w_ge   = w_try >= {1'b0, r_div};
        w_diff = w_try - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == pbms_pkg::DIV_STEP_W'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[D-1:0] : w_try[D-1:0];
            r_quo <= {r_quo[N-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ===== hw/rtl/pbms_sqrt.sv =====
`default_nettype none
module pbms_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [pbms_pkg::VAR_W-1:0]   i_value,
    output logic                              o_done,
    output logic      [pbms_pkg::SD_W-1:0]    o_root
);
    localparam int W = pbms_pkg::SQRT_W;

    logic                             r_busy;
    logic                             r_done;
    logic [pbms_pkg::SQRT_CNT_W-1:0]  r_step;
    logic [W-1:0]                     r_x;
    logic [W-1:0]                     r_res;
    logic [W-1:0]                     r_bit;
    logic [W-1:0]                     w_trial;

    assign w_trial = r_res + r_bit;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == pbms_pkg::SQRT_CNT_W'(pbms_pkg::SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one root digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= W'(i_value);
            r_res <= '0;
            r_bit <= W'(1) << (W - 2);
        end else if (r_busy) begin
            if (r_x >= w_trial) begin
                r_x   <= r_x - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[pbms_pkg::SD_W-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/per_bin_mean_variance_stats.sv =====
`default_nettype none
// channel   direction  handshake                   payload
// request   in         i_in_valid / o_in_ready     i_func, i_bin_index, i_sample
// result    out        o_out_valid / i_out_ready   o_status, o_mean_out,
//                                                  o_variance_out, o_std_dev_out,
//                                                  o_count_out
// one request at a time; an update runs accept, table read and write back,
// result load; a bad bin or unused code skips the table; a bin query runs
// two divides and a root, only the root on an empty bin; a global query walks
// every bin (two divides per filled one), then one divide and a root if not empty
// reset clears the bin valid flags at once, so the table reads as zero
// a stalled result is held in the output register; one further request may
// be taken and worked on meanwhile, and it waits to load until the result leaves
module per_bin_mean_variance_stats (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [pbms_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [pbms_pkg::INDEX_W-1:0]    i_bin_index,
    input  wire logic signed [pbms_pkg::SMP_IN_W-1:0] i_sample,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [pbms_pkg::STAT_W-1:0]     o_status,
    output logic signed [pbms_pkg::MOUT_W-1:0]   o_mean_out,
    output logic      [pbms_pkg::VAR_W-1:0]      o_variance_out,
    output logic      [pbms_pkg::SD_W-1:0]       o_std_dev_out,
    output logic      [pbms_pkg::CNT_W-1:0]      o_count_out
);
    localparam int BIN_W  = pbms_pkg::BIN_W;
    localparam int SUM_W  = pbms_pkg::SUM_W;
    localparam int SQ_W   = pbms_pkg::SQ_W;
    localparam int CNT_W  = pbms_pkg::CNT_W;
    localparam int SMP_W  = pbms_pkg::SMP_W;
    localparam int IN_W   = pbms_pkg::SMP_IN_W;
    localparam int MEAN_W = pbms_pkg::MEAN_W;
    localparam int VAR_W  = pbms_pkg::VAR_W;
    localparam int TSUM_W = pbms_pkg::TSUM_W;
    localparam int TCNT_W = pbms_pkg::TCNT_W;
    localparam int VSUM_W = pbms_pkg::VSUM_W;
    localparam int N_W    = pbms_pkg::DIV_N_W;
    localparam int D_W    = pbms_pkg::DIV_D_W;
    localparam int NUM_BINS_W = pbms_pkg::NUM_BINS;

    // sample sign position for narrower sample formats
    localparam bit SMP_SIGNED = pbms_pkg::SAMPLE_BITS <= IN_W;
    localparam int SIGN_POS   = SMP_SIGNED ? pbms_pkg::SAMPLE_BITS - 1 : IN_W - 1;
    localparam logic [63:0] SMP_MASK64 = (64'd1 << pbms_pkg::SAMPLE_BITS) - 64'd1;
    localparam logic [IN_W-1:0] SMP_MASK = SMP_MASK64[IN_W-1:0];
    localparam logic [SMP_W-1:0] SMP_WRAP = SMP_W'(64'd1 << pbms_pkg::SAMPLE_BITS);

    pbms_pkg::t_state r_state, n_state;
    pbms_pkg::t_ctrl  w_ctrl;

    logic [pbms_pkg::FUNC_W-1:0] r_func;
    logic [BIN_W-1:0]            r_addr;
    logic signed [SMP_W-1:0]     r_smp;
    logic [2*SMP_W-1:0]          r_smp_sq;
    logic [NUM_BINS_W-1:0]       r_valid;

    logic signed [SUM_W-1:0]     r_sum;
    logic [SQ_W-1:0]             r_sq;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_neg;
    logic signed [MEAN_W-1:0]    r_mean;
    logic [VAR_W:0]              r_msq;
    logic [VAR_W:0]              r_m2;
    logic [VAR_W-1:0]            r_var;
    logic [pbms_pkg::SD_W-1:0]   r_sd;
    logic [pbms_pkg::STAT_W-1:0] r_res_stat;
    logic [CNT_W-1:0]            r_res_cnt;
    logic signed [TSUM_W-1:0]    r_tsum;
    logic [TCNT_W-1:0]           r_tcnt;
    logic [VSUM_W-1:0]           r_vsum;

    logic                        r_out_valid;
    logic [pbms_pkg::STAT_W-1:0] r_o_stat;
    logic [pbms_pkg::MOUT_W-1:0] r_o_mean;
    logic [VAR_W-1:0]            r_o_var;
    logic [pbms_pkg::SD_W-1:0]   r_o_sd;
    logic [CNT_W-1:0]            r_o_cnt;

    logic                        w_accept;
    logic                        w_bad_bin;
    logic [IN_W-1:0]             w_raw;
    logic signed [SMP_W-1:0]     w_smp;
    logic [BIN_W-1:0]            w_raddr;
    logic [pbms_pkg::ENT_W-1:0]  w_rdata;
    logic [pbms_pkg::ENT_W-1:0]  w_wdata;
    logic signed [SUM_W-1:0]     w_e_sum;
    logic [SQ_W-1:0]             w_e_sq;
    logic [CNT_W-1:0]            w_e_cnt;
    logic [SUM_W-1:0]            w_e_mag;
    logic [TSUM_W-1:0]           w_t_mag;
    logic [VAR_W-1:0]            w_var;
    logic [N_W-1:0]              w_div_n;
    logic [D_W-1:0]              w_div_d;
    logic                        w_div_busy;
    logic                        w_div_done;
    logic [N_W-1:0]              w_div_q;
    logic signed [MEAN_W-1:0]    w_q_mean;
    logic [VAR_W-1:0]            w_sqrt_in;
    logic                        w_sqrt_done;
    logic [pbms_pkg::SD_W-1:0]   w_sqrt_out;
    logic                        w_load;
    logic                        w_last_bin;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_bad_bin  = {1'b0, i_bin_index} >= (pbms_pkg::INDEX_W + 1)'(pbms_pkg::NUM_BINS);
    assign w_load     = !r_out_valid || i_out_ready;
    assign w_last_bin = r_addr == BIN_W'(pbms_pkg::NUM_BINS - 1);

    // sample sign extension from the configured sample width
    always_comb begin
        w_raw = i_sample & SMP_MASK;
        w_smp = signed'({1'b0, w_raw});
        if (SMP_SIGNED && w_raw[SIGN_POS]) begin
            w_smp = signed'({1'b0, w_raw} - SMP_WRAP);
        end
    end

    // table entry as read, invalid entries read as zero
    always_comb begin
        w_e_sum = '0;
        w_e_sq  = '0;
        w_e_cnt = '0;
        if (r_valid[r_addr]) begin
            {w_e_sum, w_e_sq, w_e_cnt} = w_rdata;
        end
        w_e_mag = w_e_sum[SUM_W-1] ? SUM_W'(-w_e_sum) : SUM_W'(w_e_sum);
        w_t_mag = r_tsum[TSUM_W-1] ? TSUM_W'(-r_tsum) : TSUM_W'(r_tsum);
        w_wdata = {SUM_W'(w_e_sum + SUM_W'(r_smp)),
                   SQ_W'(w_e_sq + SQ_W'(r_smp_sq)),
                   CNT_W'(w_e_cnt + 1'b1)};
    end

    // variance clamp and signed quotient
    always_comb begin
        w_var    = (r_msq > r_m2) ? VAR_W'(r_msq - r_m2) : '0;
        w_q_mean = r_neg ? MEAN_W'(-signed'(w_div_q[MEAN_W-1:0]))
                         : signed'(w_div_q[MEAN_W-1:0]);
    end

    // read address: request bin or first bin on accept, next bin in the walk
    always_comb begin
        if (r_state == pbms_pkg::S_IDLE) begin
            w_raddr = (i_func == pbms_pkg::FN_GLOBAL) ? '0 : i_bin_index[BIN_W-1:0];
        end else begin
            w_raddr = BIN_W'(r_addr + 1'b1);
        end
    end

    // divider and square root operand select
    always_comb begin
        w_div_n = '0;
        w_div_d = '0;
        case (r_state)
            pbms_pkg::S_RD: begin
                w_div_n = N_W'(w_e_mag);
                w_div_d = D_W'(w_e_cnt);
            end
            pbms_pkg::S_DIVM: begin
                w_div_n = r_sq;
                w_div_d = D_W'(r_cnt);
            end
            pbms_pkg::S_GEND: begin
                w_div_n = N_W'(w_t_mag);
                w_div_d = r_tcnt;
            end
            default: begin
                w_div_n = '0;
                w_div_d = '0;
            end
        endcase
        w_sqrt_in = (r_state == pbms_pkg::S_VAR) ? w_var : r_var;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pbms_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_func == pbms_pkg::FN_GLOBAL) begin
                        n_state = pbms_pkg::S_RD;
                    end else if (i_func == pbms_pkg::FN_ADD || i_func == pbms_pkg::FN_QUERY) begin
                        n_state = w_bad_bin ? pbms_pkg::S_FIN : pbms_pkg::S_RD;
                    end else begin
                        n_state = pbms_pkg::S_FIN;
                    end
                end
            end
            pbms_pkg::S_RD: begin
                if (r_func == pbms_pkg::FN_ADD) begin
                    n_state = pbms_pkg::S_FIN;
                end else if (w_e_cnt == '0) begin
                    n_state = pbms_pkg::S_VAR;
                end else begin
                    n_state = pbms_pkg::S_DIVM;
                end
            end
            pbms_pkg::S_DIVM: begin
                if (w_div_done) n_state = pbms_pkg::S_DIVQ;
            end
            pbms_pkg::S_DIVQ: begin
                if (w_div_done) n_state = pbms_pkg::S_MUL;
            end
            pbms_pkg::S_MUL: begin
                n_state = pbms_pkg::S_VAR;
            end
            pbms_pkg::S_VAR: begin
                if (r_func == pbms_pkg::FN_QUERY) begin
                    n_state = pbms_pkg::S_SQRT;
                end else begin
                    n_state = w_last_bin ? pbms_pkg::S_GEND : pbms_pkg::S_RD;
                end
            end
            pbms_pkg::S_GEND: begin
                n_state = (r_tcnt == '0) ? pbms_pkg::S_FIN : pbms_pkg::S_GDIVM;
            end
            pbms_pkg::S_GDIVM: begin
                if (w_div_done) n_state = pbms_pkg::S_SQRT;
            end
            pbms_pkg::S_SQRT: begin
                if (w_sqrt_done) n_state = pbms_pkg::S_FIN;
            end
            pbms_pkg::S_FIN: begin
                if (w_load) n_state = pbms_pkg::S_IDLE;
            end
            default: n_state = pbms_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_ctrl = '0;
        case (r_state)
            pbms_pkg::S_IDLE: w_ctrl.in_ready = 1'b1;
            pbms_pkg::S_RD: begin
                w_ctrl.ram_we    = (r_func == pbms_pkg::FN_ADD) && (w_e_cnt != pbms_pkg::COUNT_MAX);
                w_ctrl.div_start = (r_func != pbms_pkg::FN_ADD) && (w_e_cnt != '0);
            end
            pbms_pkg::S_DIVM:  w_ctrl.div_start  = w_div_done;
            pbms_pkg::S_VAR:   w_ctrl.sqrt_start = (r_func == pbms_pkg::FN_QUERY);
            pbms_pkg::S_GEND:  w_ctrl.div_start  = (r_tcnt != '0);
            pbms_pkg::S_GDIVM: w_ctrl.sqrt_start = w_div_done;
            default:           w_ctrl = '0;
        endcase
    end

    // state and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbms_pkg::S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctrl.ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (r_state == pbms_pkg::S_FIN && w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            pbms_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_func     <= i_func;
                    r_addr     <= w_raddr;
                    r_smp      <= w_smp;
                    r_smp_sq   <= unsigned'((2 * SMP_W)'(w_smp) * (2 * SMP_W)'(w_smp));
                    r_tsum     <= '0;
                    r_tcnt     <= '0;
                    r_vsum     <= '0;
                    r_mean     <= '0;
                    r_var      <= '0;
                    r_sd       <= '0;
                    r_res_cnt  <= '0;
                    r_res_stat <= pbms_pkg::ST_OK;
                    if ((i_func == pbms_pkg::FN_ADD || i_func == pbms_pkg::FN_QUERY)
                            && w_bad_bin) begin
                        r_res_stat <= pbms_pkg::ST_BAD_BIN;
                    end
                end
            end
            pbms_pkg::S_RD: begin
                r_sum <= w_e_sum;
                r_sq  <= w_e_sq;
                r_cnt <= w_e_cnt;
                r_neg <= w_e_sum[SUM_W-1];
                r_msq <= '0;
                r_m2  <= '0;
                r_mean <= '0;
                if (r_func == pbms_pkg::FN_ADD) begin
                    if (w_e_cnt == pbms_pkg::COUNT_MAX) begin
                        r_res_stat <= pbms_pkg::ST_SAT;
                        r_res_cnt  <= pbms_pkg::COUNT_MAX;
                    end else begin
                        r_res_cnt <= CNT_W'(w_e_cnt + 1'b1);
                    end
                end
            end
            pbms_pkg::S_DIVM: begin
                if (w_div_done) r_mean <= w_q_mean;
            end
            pbms_pkg::S_DIVQ: begin
                if (w_div_done) r_msq <= w_div_q[VAR_W:0];
            end
            pbms_pkg::S_MUL: begin
                r_m2 <= unsigned'((VAR_W + 1)'(r_mean) * (VAR_W + 1)'(r_mean));
            end
            pbms_pkg::S_VAR: begin
                if (r_func == pbms_pkg::FN_QUERY) begin
                    r_var     <= w_var;
                    r_res_cnt <= r_cnt;
                end else begin
                    r_tsum <= TSUM_W'(r_tsum + TSUM_W'(r_sum));
                    r_tcnt <= TCNT_W'(r_tcnt + TCNT_W'(r_cnt));
                    r_vsum <= VSUM_W'(r_vsum + VSUM_W'(w_var));
                    r_addr <= w_raddr;
                end
            end
            pbms_pkg::S_GEND: begin
                r_neg <= r_tsum[TSUM_W-1];
                // mean of the per-bin variances
                r_var <= VAR_W'(r_vsum / VSUM_W'(pbms_pkg::NUM_BINS));
                if (r_tcnt == '0) begin
                    r_res_stat <= pbms_pkg::ST_EMPTY;
                end else if (r_tcnt > TCNT_W'(pbms_pkg::COUNT_MAX)) begin
                    r_res_stat <= pbms_pkg::ST_SAT;
                    r_res_cnt  <= pbms_pkg::COUNT_MAX;
                end else begin
                    r_res_cnt <= r_tcnt[CNT_W-1:0];
                end
            end
            pbms_pkg::S_GDIVM: begin
                if (w_div_done) r_mean <= w_q_mean;
            end
            pbms_pkg::S_SQRT: begin
                if (w_sqrt_done) r_sd <= w_sqrt_out;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == pbms_pkg::S_FIN && w_load) begin
            r_o_stat <= r_res_stat;
            r_o_mean <= r_mean[pbms_pkg::MOUT_W-1:0];
            r_o_var  <= r_var;
            r_o_sd   <= r_sd;
            r_o_cnt  <= r_res_cnt;
        end
    end

    pbms_ram #(
        .WIDTH (pbms_pkg::ENT_W),
        .DEPTH (pbms_pkg::NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctrl.ram_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pbms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_ctrl.div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    pbms_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctrl.sqrt_start),
        .i_value (w_sqrt_in),
        .o_done  (w_sqrt_done),
        .o_root  (w_sqrt_out)
    );

    assign o_in_ready     = w_ctrl.in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_stat;
    assign o_mean_out     = signed'(r_o_mean);
    assign o_variance_out = r_o_var;
    assign o_std_dev_out  = r_o_sd;
    assign o_count_out    = r_o_cnt;

    // table writes only from an update in the read state
    a_we_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ram_we |-> (r_state == pbms_pkg::S_RD && r_func == pbms_pkg::FN_ADD))
        else $error("table write outside update");

    // divider never restarted while busy
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.div_start |-> !w_div_busy)
        else $error("divider started while busy");

    // empty global result carries zero count
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_stat == pbms_pkg::ST_EMPTY) |-> (r_o_cnt == '0))
        else $error("empty global with nonzero count");

    // no result right after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    import pbms_pkg::*;

    localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;
    localparam int LIMIT = 10000000;
    localparam int N_RANDOM = 1030;

    // expected result of one request
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [MOUT_W-1:0] mean;
        logic [VAR_W-1:0]  variance;
        logic [SD_W-1:0]   std_dev;
        logic [CNT_W-1:0]  count;
    } t_stat_res;

    // one row of the directed table
    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [INDEX_W-1:0]  bin;
        logic [SMP_IN_W-1:0] smp;
        bit                  lit;
        t_stat_res           res;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [FUNC_W-1:0] i_func = '0;
    logic [INDEX_W-1:0] i_bin_index = '0;
    logic signed [SMP_IN_W-1:0] i_sample = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic signed [MOUT_W-1:0] o_mean_out;
    logic [VAR_W-1:0] o_variance_out;
    logic [SD_W-1:0] o_std_dev_out;
    logic [CNT_W-1:0] o_count_out;

    per_bin_mean_variance_stats dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow copy of the bin table
    longint          shadow_sum [NUM_BINS];
    longint unsigned shadow_sq  [NUM_BINS];
    longint unsigned shadow_cnt [NUM_BINS];

    t_stat_res pending_results[$];
    int  errors = 0;
    int  cycle = 0;
    int  stall = 0;
    bit  calm = 1'b0;
    t_dir_row dir_rows[$];

    // floor square root by binary search
    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd4294967296;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= x) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // signed divide truncated toward zero
    function automatic longint div_trunc(longint n, longint unsigned d);
        longint unsigned q;
        q = ((n < 0) ? longint'(-n) : n) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    // mean and clamped variance of one bin
    function automatic longint unsigned bin_var(int b, output longint m);
        longint unsigned msq, m2;
        if (shadow_cnt[b] == 0) begin
            m = 0;
            return 0;
        end
        m = div_trunc(shadow_sum[b], shadow_cnt[b]);
        msq = shadow_sq[b] / shadow_cnt[b];
        m2 = longint'(m * m);
        return (msq > m2) ? msq - m2 : 0;
    endfunction

    // advance the shadow table by one request and form its result
    function automatic t_stat_res stats_predict(logic [FUNC_W-1:0] f,
                                                logic [INDEX_W-1:0] b,
                                                logic [SMP_IN_W-1:0] s);
        t_stat_res r;
        longint m, v, tsum;
        longint unsigned var_v, tcnt, vsum, root;
        r = '{default: '0};
        if (f == FN_ADD || f == FN_QUERY) begin
            if (b >= NUM_BINS) begin
                r.status = ST_BAD_BIN;
            end else if (f == FN_ADD) begin
                if (shadow_cnt[b] >= COUNT_MAX) begin
                    r.status = ST_SAT;
                    r.count = COUNT_MAX;
                end else begin
                    v = longint'($signed(s));
                    shadow_sum[b] += v;
                    shadow_sq[b] += longint'(v * v);
                    shadow_cnt[b] += 1;
                    r.count = shadow_cnt[b][CNT_W-1:0];
                end
            end else begin
                var_v = bin_var(b, m);
                root = floor_root(var_v);
                r.mean = m[MOUT_W-1:0];
                r.variance = var_v[VAR_W-1:0];
                r.std_dev = root[SD_W-1:0];
                r.count = shadow_cnt[b][CNT_W-1:0];
            end
        end else if (f == FN_GLOBAL) begin
            tsum = 0;
            tcnt = 0;
            vsum = 0;
            for (int i = 0; i < NUM_BINS; i++) begin
                tsum += shadow_sum[i];
                tcnt += shadow_cnt[i];
                vsum += bin_var(i, m);
            end
            if (tcnt == 0) begin
                r.status = ST_EMPTY;
            end else begin
                m = div_trunc(tsum, tcnt);
                var_v = vsum / NUM_BINS;
                root = floor_root(var_v);
                r.status = (tcnt > COUNT_MAX) ? ST_SAT : ST_OK;
                r.mean = m[MOUT_W-1:0];
                r.variance = var_v[VAR_W-1:0];
                r.std_dev = root[SD_W-1:0];
                r.count = (tcnt > COUNT_MAX) ? COUNT_MAX : tcnt[CNT_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle);
        errors++;
    endtask

    // gap before a request or a stall length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // drive one request and record its expected result on acceptance
    task automatic send_req(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] b,
                            logic [SMP_IN_W-1:0] s, bit lit, t_stat_res lit_res);
        int g;
        t_stat_res p;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_bin_index <= b;
        i_sample <= s;
        do @(posedge i_clk); while (!o_in_ready);
        p = stats_predict(f, b, s);
        pending_results = {pending_results, (lit ? lit_res : p)};
    endtask

    function automatic t_dir_row mk(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] b,
                                    logic [SMP_IN_W-1:0] s, bit lit,
                                    logic [STAT_W-1:0] st, logic [CNT_W-1:0] c);
        t_dir_row d;
        d.func = f;
        d.bin = b;
        d.smp = s;
        d.lit = lit;
        d.res = '{default: '0};
        d.res.status = st;
        d.res.count = c;
        return d;
    endfunction

    // append one row to the directed table
    function automatic void add_row(t_dir_row d);
        dir_rows = {dir_rows, d};
    endfunction

    // result side: random stalls and checking
    always @(posedge i_clk) begin
        t_stat_res e;
        cycle <= cycle + 1;
        if (cycle % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (cycle > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", o_status, 0);
            end else begin
                e = pending_results.pop_front();
                if (o_status !== e.status) report("status", o_status, e.status);
                if (o_mean_out !== e.mean) report("mean", o_mean_out, e.mean);
                if (o_variance_out !== e.variance)
                    report("variance", o_variance_out, e.variance);
                if (o_std_dev_out !== e.std_dev)
                    report("std_dev", o_std_dev_out, e.std_dev);
                if (o_count_out !== e.count) report("count", o_count_out, e.count);
            end
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall > 0) begin
            stall <= stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            stall <= pick_gap();
            i_out_ready <= 1'b1;
        end
    end

    // stimulus
    initial begin
        logic [FUNC_W-1:0] f;
        logic [INDEX_W-1:0] b;
        logic [SMP_IN_W-1:0] s;
        int r;
        for (int i = 0; i < NUM_BINS; i++) begin
            shadow_sum[i] = 0;
            shadow_sq[i] = 0;
            shadow_cnt[i] = 0;
        end
        // empty table, bad indexes, unused code, sample extremes, then bin and global queries
        add_row(mk(FN_GLOBAL, 8'd0,   16'h0000, 1, ST_EMPTY,   0));
        add_row(mk(FN_QUERY,  8'd0,   16'h0000, 1, ST_OK,      0));
        add_row(mk(FN_ADD,    8'd255, 16'h7fff, 1, ST_BAD_BIN, 0));
        add_row(mk(FN_QUERY,  8'd16,  16'h0000, 1, ST_BAD_BIN, 0));
        add_row(mk(FN_NONE,   8'd5,   16'hffff, 1, ST_OK,      0));
        add_row(mk(FN_ADD,    8'd0,   16'h7fff, 1, ST_OK,      1));
        add_row(mk(FN_ADD,    8'd0,   16'h8000, 1, ST_OK,      2));
        add_row(mk(FN_QUERY,  8'd0,   16'h0000, 0, ST_OK,      0));
        add_row(mk(FN_ADD,    8'd15,  16'h0000, 1, ST_OK,      1));
        add_row(mk(FN_QUERY,  8'd15,  16'h0000, 0, ST_OK,      0));
        add_row(mk(FN_ADD,    8'd15,  16'hffff, 1, ST_OK,      2));
        add_row(mk(FN_ADD,    8'd7,   16'h0100, 1, ST_OK,      1));
        add_row(mk(FN_ADD,    8'd7,   16'h0300, 1, ST_OK,      2));
        add_row(mk(FN_QUERY,  8'd7,   16'h0000, 0, ST_OK,      0));
        add_row(mk(FN_GLOBAL, 8'd255, 16'h5a5a, 0, ST_OK,      0));
        add_row(mk(FN_ADD,    8'd16,  16'h1234, 1, ST_BAD_BIN, 0));
        add_row(mk(FN_QUERY,  8'd255, 16'h0000, 1, ST_BAD_BIN, 0));
        add_row(mk(FN_ADD,    8'd3,   16'h8000, 1, ST_OK,      1));
        add_row(mk(FN_QUERY,  8'd3,   16'h0000, 0, ST_OK,      0));
        add_row(mk(FN_GLOBAL, 8'd0,   16'h0000, 0, ST_OK,      0));
        add_row(mk(FN_NONE,   8'd0,   16'h0000, 1, ST_OK,      0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_req(dir_rows[k].func, dir_rows[k].bin, dir_rows[k].smp,
                     dir_rows[k].lit, dir_rows[k].res);

        // random mix, mostly updates to valid bins
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            b = INDEX_W'($urandom_range(0, NUM_BINS - 1));
            if (r < 65) begin
                f = FN_ADD;
            end else if (r < 70) begin
                f = FN_ADD;
                b = INDEX_W'($urandom_range(0, 255));
            end else if (r < 88) begin
                f = FN_QUERY;
            end else if (r < 91) begin
                f = FN_QUERY;
                b = INDEX_W'($urandom_range(0, 255));
            end else if (r < 97) begin
                f = FN_GLOBAL;
                b = INDEX_W'($urandom_range(0, 255));
            end else begin
                f = FN_NONE;
                b = INDEX_W'($urandom_range(0, 255));
            end
            // per-bin offset keeps means apart, full range stresses variance
            if ($urandom_range(0, 1))
                s = SMP_IN_W'($urandom_range(0, 65535));
            else
                s = 16'(b * 4099) + 16'($urandom_range(0, 511));
            send_req(f, b, s, 1'b0, '{default: '0});
        end
        i_in_valid <= 1'b0;

        // drain and let the block settle
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
